>>> rtl/assert_macros.svh
// Assertion macros shared by the call number history display RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, skipped while reset is asserted.
`define CNHD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define CNHD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> rtl/cnhd_pkg.sv
// Shared types, constants and helper functions for the call number history display.
`timescale 1ns / 1ps
package cnhd_pkg;

    localparam int HIST_DEPTH = 5;
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
    localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_CALL   = 2'd1;
    localparam logic [1:0] CMD_REVIEW = 2'd2;

    localparam logic CFG_TICKS_PER_SEC = 1'b0;
    localparam logic CFG_TIMEOUT_SEC   = 1'b1;

    localparam logic [7:0] TPS_RESET     = 8'd50;
    localparam logic [7:0] TIMEOUT_RESET = 8'd60;
    localparam logic [6:0] MAX_CALL      = 7'd99;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0] command;
        logic [6:0] call_number;
    } t_in_word;

    typedef struct packed {
        logic [3:0] units_digit;
        logic [3:0] tens_digit;
        logic [7:0] units_segments;
        logic [7:0] tens_segments;
        logic       review_active;
        logic [2:0] entries_held;
    } t_out_word;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } t_digits;

    // Compare token walking down the cell row.
    typedef struct packed {
        logic    valid;
        logic    match;
        t_digits digits;
    } t_tok;

    // Active-low seven-segment pattern for one decimal digit.
    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'b1010_0000;
            4'd1:    seg = 8'b1111_1001;
            4'd2:    seg = 8'b0110_0100;
            4'd3:    seg = 8'b0111_0000;
            4'd4:    seg = 8'b0011_1001;
            4'd5:    seg = 8'b0011_0010;
            4'd6:    seg = 8'b0010_0010;
            4'd7:    seg = 8'b1111_1000;
            4'd8:    seg = 8'b0010_0000;
            default: seg = 8'b0011_0000;
        endcase
        return seg;
    endfunction

    // Split a saturated call number into tens and units (n * 205 >> 11 is n / 10 below 180).
    function automatic t_digits split_call(input logic [6:0] num);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        t_digits     res;
        prod      = 15'(num) * 15'd205;
        tens      = prod[14:11];
        tens_x10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
        res.tens  = tens;
        res.units = 4'(num - tens_x10);
        return res;
    endfunction

endpackage

>>> rtl/call_number_history_display.sv
// Top level: command sequencer, timers and the row of history cells.
//
//   channel   direction  handshake              payload
//   command   in         i_start & !o_busy      i_in  (t_in_word)
//   result    out        o_done, one cycle      o_out (t_out_word)
//   config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// A tick, review or idle command steps through S_EXEC and S_OUT; o_done is registered from S_OUT.
// A call also passes through S_SCAN, where its duplicate check walks the cell row,
// one cell per cycle. o_busy is high from accept until the strobe cycle.
// Reset (synchronous, active low) empties the history and enters review mode.
// The receiver cannot stall; each word is shown for one cycle only.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module call_number_history_display (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  cnhd_pkg::t_in_word  i_in,
    output logic                o_done,
    output cnhd_pkg::t_out_word o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [7:0]          i_cfg_data
);

    localparam int D  = cnhd_pkg::HIST_DEPTH;
    localparam int CW = cnhd_pkg::CNT_W;
    localparam int IW = cnhd_pkg::IDX_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(D);

    cnhd_pkg::t_state r_state, n_state;

    logic [7:0]    r_tps, r_timeout;
    logic [1:0]    r_cmd;
    logic [6:0]    r_num;
    cnhd_pkg::t_digits r_new;
    logic [CW-1:0] r_wslot, n_wslot;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rslot, n_rslot;
    logic [7:0]    r_pass, n_pass;
    logic [7:0]    r_secs, n_secs;
    logic          r_review, n_review;
    logic          r_done;
    cnhd_pkg::t_out_word r_out, n_out;

    cnhd_pkg::t_tok    w_tok [D+1];
    cnhd_pkg::t_digits w_cell [D];
    logic [D-1:0]      w_held;
    logic [D-1:0]      w_wr_en;
    logic              w_launch;
    logic              w_accept;
    logic              w_scan_end;
    logic [CW-1:0]     w_wr_slot;
    logic [8:0]        w_pass_inc;
    logic [CW:0]       w_rslot_inc;
    logic              w_show;
    logic [CW-1:0]     w_slot;
    cnhd_pkg::t_digits w_shown;

    assign w_accept   = i_start && !o_busy;
    assign w_scan_end = (r_state == cnhd_pkg::S_SCAN) && w_tok[D].valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cnhd_pkg::S_IDLE: if (w_accept) n_state = cnhd_pkg::S_EXEC;
            cnhd_pkg::S_EXEC: begin
                n_state = (r_cmd == cnhd_pkg::CMD_CALL) ? cnhd_pkg::S_SCAN : cnhd_pkg::S_OUT;
            end
            cnhd_pkg::S_SCAN: if (w_tok[D].valid) n_state = cnhd_pkg::S_OUT;
            cnhd_pkg::S_OUT:  n_state = cnhd_pkg::S_IDLE;
            default:          n_state = cnhd_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_busy   = 1'b1;
        w_launch = 1'b0;
        unique case (r_state)
            cnhd_pkg::S_IDLE: o_busy = 1'b0;
            cnhd_pkg::S_EXEC: w_launch = (r_cmd == cnhd_pkg::CMD_CALL);
            cnhd_pkg::S_SCAN: o_busy = 1'b1;
            cnhd_pkg::S_OUT:  o_busy = 1'b1;
            default:          o_busy = 1'b1;
        endcase
    end

    // cell row; the token carries the digits of the call being checked
    always_comb begin
        w_tok[0].valid  = w_launch;
        w_tok[0].match  = 1'b0;
        w_tok[0].digits = cnhd_pkg::split_call(r_num);
    end

    assign w_wr_slot = (r_wslot >= DEPTH_C) ? '0 : r_wslot;

    for (genvar g = 0; g < D; g++) begin : g_cell
        assign w_held[g]  = CW'(g) < r_count;
        assign w_wr_en[g] = w_scan_end && !w_tok[D].match && (w_wr_slot == CW'(g));
        cnhd_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (w_tok[g]),
            .i_held      (w_held[g]),
            .i_wr_en     (w_wr_en[g]),
            .i_wr_digits (r_new),
            .o_tok       (w_tok[g+1]),
            .o_digits    (w_cell[g])
        );
    end

    assign w_pass_inc  = {1'b0, r_pass} + 9'd1;
    assign w_rslot_inc = {1'b0, r_rslot} + 1'b1;

    // history, timers and mode
    always_comb begin
        n_wslot  = r_wslot;
        n_count  = r_count;
        n_rslot  = r_rslot;
        n_pass   = r_pass;
        n_secs   = r_secs;
        n_review = r_review;
        if (r_state == cnhd_pkg::S_EXEC) begin
            case (r_cmd)
                cnhd_pkg::CMD_TICK: begin
                    if (w_pass_inc < {1'b0, r_tps}) begin
                        n_pass = w_pass_inc[7:0];
                    end else begin
                        n_pass = '0;
                        if (r_secs == '0) begin
                            // timeout: drop the history, back to normal mode
                            n_wslot  = '0;
                            n_count  = '0;
                            n_rslot  = '0;
                            n_review = 1'b0;
                        end else begin
                            n_secs = r_secs - 8'd1;
                            if (r_review) begin
                                if (r_count == '0 || w_rslot_inc >= {1'b0, r_count}) begin
                                    n_rslot = '0;
                                end else begin
                                    n_rslot = w_rslot_inc[CW-1:0];
                                end
                            end
                        end
                    end
                end
                cnhd_pkg::CMD_CALL: n_secs = r_timeout;
                cnhd_pkg::CMD_REVIEW: begin
                    n_review = 1'b1;
                    // start from the oldest entry
                    if (r_wslot == r_count || r_wslot >= DEPTH_C) begin
                        n_rslot = '0;
                    end else begin
                        n_rslot = r_wslot;
                    end
                end
                default: n_review = r_review;
            endcase
        end
        if (w_scan_end && !w_tok[D].match) begin
            n_wslot = w_wr_slot + 1'b1;
            if (r_count < DEPTH_C) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    // display word
    always_comb begin
        if (r_review) begin
            w_slot = r_rslot;
            w_show = (r_count != '0) && (r_rslot < r_count);
        end else begin
            w_show = (r_wslot != '0);
            w_slot = r_wslot - 1'b1;
        end
        w_shown = '0;
        if (w_show && w_slot < DEPTH_C) begin
            w_shown = w_cell[w_slot[IW-1:0]];
        end
        n_out.units_digit    = w_shown.units;
        n_out.tens_digit     = w_shown.tens;
        n_out.units_segments = cnhd_pkg::seg_of(w_shown.units);
        n_out.tens_segments  = cnhd_pkg::seg_of(w_shown.tens);
        n_out.review_active  = r_review;
        n_out.entries_held   = 3'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cnhd_pkg::S_IDLE;
            r_tps    <= cnhd_pkg::TPS_RESET;
            r_timeout <= cnhd_pkg::TIMEOUT_RESET;
            r_wslot  <= '0;
            r_count  <= '0;
            r_rslot  <= '0;
            r_pass   <= '0;
            r_secs   <= '0;
            r_review <= 1'b1;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wslot  <= n_wslot;
            r_count  <= n_count;
            r_rslot  <= n_rslot;
            r_pass   <= n_pass;
            r_secs   <= n_secs;
            r_review <= n_review;
            r_done   <= (r_state == cnhd_pkg::S_OUT);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cnhd_pkg::CFG_TICKS_PER_SEC: r_tps     <= i_cfg_data;
                    cnhd_pkg::CFG_TIMEOUT_SEC:   r_timeout <= i_cfg_data;
                    default:                     r_tps     <= r_tps;
                endcase
            end
        end
        if (w_accept) begin
            r_cmd <= i_in.command;
            r_num <= (i_in.call_number > cnhd_pkg::MAX_CALL) ? cnhd_pkg::MAX_CALL
                                                             : i_in.call_number;
        end
        if (r_state == cnhd_pkg::S_EXEC) begin
            r_new <= cnhd_pkg::split_call(r_num);
        end
        if (r_state == cnhd_pkg::S_OUT) begin
            r_out <= n_out;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

    `CNHD_ASSERT(a_done_after_out, i_clk, i_rst_n, o_done |-> $past(r_state == cnhd_pkg::S_OUT), "result word without a display load")
    `CNHD_ASSERT(a_done_not_busy, i_clk, i_rst_n, o_done |-> !o_busy, "result word while still busy")
    `CNHD_ASSERT(a_token_in_scan, i_clk, i_rst_n, w_tok[D].valid |-> (r_state == cnhd_pkg::S_SCAN), "token left the cell row outside a scan")
    `CNHD_ASSERT(a_fill_order, i_clk, i_rst_n, (r_count < DEPTH_C) |-> (r_wslot == r_count), "write slot out of step with fill count")
    `CNHD_ASSERT(a_count_range, i_clk, i_rst_n, (r_count <= DEPTH_C) && (r_wslot <= DEPTH_C), "history count past depth")

endmodule

>>> rtl/cnhd_cell.sv
// One history cell: holds a stored call and checks the passing token against it.
`timescale 1ns / 1ps
module cnhd_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cnhd_pkg::t_tok    i_tok,
    input  logic             i_held,
    input  logic             i_wr_en,
    input  cnhd_pkg::t_digits i_wr_digits,
    output cnhd_pkg::t_tok    o_tok,
    output cnhd_pkg::t_digits o_digits
);

    cnhd_pkg::t_digits r_digits;
    cnhd_pkg::t_tok    r_tok;
    cnhd_pkg::t_tok    n_tok;

    always_comb begin
        n_tok       = i_tok;
        // fold this entry's compare into the running match flag
        n_tok.match = i_tok.match | (i_held && (r_digits == i_tok.digits));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.match  <= n_tok.match;
        r_tok.digits <= n_tok.digits;
        if (i_wr_en) begin
            r_digits <= i_wr_digits;
        end
    end

    assign o_tok    = r_tok;
    assign o_digits = r_digits;

endmodule

>>> tb/sv/call_display_checker.sv
// Checker for the call number display: predicts each display word and compares it.
`timescale 1ns / 1ps
module call_display_checker
    import cnhd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_in_word  i_in,
    input  logic      i_done,
    input  t_out_word i_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output int        o_fail_count,
    output int        o_words_waiting
);

    // Active-low patterns for digits 9 down to 0.
    localparam logic [79:0] DIGIT_SEGS = {
        8'h30, 8'h20, 8'hF8, 8'h22, 8'h32, 8'h39, 8'h70, 8'h64, 8'hF9, 8'hA0
    };

    logic [7:0] ticks_per_sec;
    logic [7:0] timeout_sec;
    logic [3:0] units_hist [HIST_DEPTH];
    logic [3:0] tens_hist [HIST_DEPTH];
    logic [2:0] wr_slot;
    logic [2:0] n_held;
    logic [2:0] rv_slot;
    logic [7:0] pass_cnt;
    logic [7:0] secs_left;
    logic       reviewing;

    t_out_word  shown_q [$];

    initial begin
        o_fail_count    = 0;
        o_words_waiting = 0;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("%0t: display mismatch on %s: got %0d, want %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic wipe_history();
        for (int i = 0; i < HIST_DEPTH; i++) begin
            units_hist[i] = '0;
            tens_hist[i]  = '0;
        end
        wr_slot = '0;
        n_held  = '0;
        rv_slot = '0;
    endtask

    // Apply one command word and work out the display word that follows it.
    task automatic advance_history(input t_in_word w, output t_out_word shown);
        logic [6:0] num;
        logic [3:0] u;
        logic [3:0] t;
        logic [8:0] nxt;
        logic [2:0] slot;
        logic       show;
        logic       dup;
        case (w.command)
            CMD_TICK: begin
                nxt = {1'b0, pass_cnt} + 9'd1;
                if (nxt < {1'b0, ticks_per_sec}) begin
                    pass_cnt = nxt[7:0];
                end else begin
                    pass_cnt = '0;
                    if (secs_left == 0) begin
                        wipe_history();
                        reviewing = 1'b0;
                    end else begin
                        secs_left = secs_left - 8'd1;
                    end
                    if (reviewing) begin
                        if (n_held == 0 || {1'b0, rv_slot} + 4'd1 >= {1'b0, n_held})
                            rv_slot = '0;
                        else
                            rv_slot = rv_slot + 3'd1;
                    end
                end
            end
            CMD_CALL: begin
                num = (w.call_number > MAX_CALL) ? MAX_CALL : w.call_number;
                u = 4'(num % 7'd10);
                t = 4'(num / 7'd10);
                secs_left = timeout_sec;
                dup = 1'b0;
                for (int i = 0; i < HIST_DEPTH; i++) begin
                    if (i < n_held && units_hist[i] == u && tens_hist[i] == t)
                        dup = 1'b1;
                end
                if (!dup) begin
                    if (wr_slot >= HIST_DEPTH)
                        wr_slot = '0;
                    units_hist[wr_slot] = u;
                    tens_hist[wr_slot]  = t;
                    if (n_held < HIST_DEPTH)
                        n_held = n_held + 3'd1;
                    wr_slot = wr_slot + 3'd1;
                end
            end
            CMD_REVIEW: begin
                reviewing = 1'b1;
                if (wr_slot == n_held || wr_slot >= HIST_DEPTH)
                    rv_slot = '0;
                else
                    rv_slot = wr_slot;
            end
            default: ;
        endcase

        if (reviewing) begin
            slot = rv_slot;
            show = (n_held != 0) && (slot < n_held);
        end else begin
            show = (wr_slot != 0) && (wr_slot <= HIST_DEPTH);
            slot = show ? wr_slot - 3'd1 : 3'd0;
        end
        u = '0;
        t = '0;
        if (show && slot < HIST_DEPTH) begin
            u = units_hist[slot];
            t = tens_hist[slot];
        end
        if (u > 4'd9) u = 4'd9;
        if (t > 4'd9) t = 4'd9;

        shown.units_digit    = u;
        shown.tens_digit     = t;
        shown.units_segments = DIGIT_SEGS[u * 8 +: 8];
        shown.tens_segments  = DIGIT_SEGS[t * 8 +: 8];
        shown.review_active  = reviewing;
        shown.entries_held   = n_held;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            ticks_per_sec = TPS_RESET;
            timeout_sec   = TIMEOUT_RESET;
            wipe_history();
            pass_cnt  = '0;
            secs_left = '0;
            reviewing = 1'b1;
            shown_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TICKS_PER_SEC)
                    ticks_per_sec = i_cfg_data;
                else
                    timeout_sec = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                advance_history(i_in, want);
                shown_q.push_back(want);
            end
            if (i_done) begin
                if (shown_q.size() == 0) begin
                    note_mismatch("word with nothing expected", i_out.entries_held, 0);
                end else begin
                    want = shown_q.pop_front();
                    if (i_out.units_digit !== want.units_digit)
                        note_mismatch("units_digit", i_out.units_digit, want.units_digit);
                    if (i_out.tens_digit !== want.tens_digit)
                        note_mismatch("tens_digit", i_out.tens_digit, want.tens_digit);
                    if (i_out.units_segments !== want.units_segments)
                        note_mismatch("units_segments", i_out.units_segments,
                                      want.units_segments);
                    if (i_out.tens_segments !== want.tens_segments)
                        note_mismatch("tens_segments", i_out.tens_segments,
                                      want.tens_segments);
                    if (i_out.review_active !== want.review_active)
                        note_mismatch("review_active", i_out.review_active,
                                      want.review_active);
                    if (i_out.entries_held !== want.entries_held)
                        note_mismatch("entries_held", i_out.entries_held, want.entries_held);
                end
            end
        end
        o_words_waiting = shown_q.size();
    end

endmodule

>>> tb/sv/call_number_history_display_test.sv
// Top of the call number display testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module call_number_history_display_test;
    import cnhd_pkg::*;

    localparam logic [1:0] CMD_IDLE   = 2'd3;
    localparam int         STALL_MAX  = 3000;
    localparam int         N_PHASES   = 7;
    localparam int         PHASE_LEN  = 130;
    localparam int         POOL_SIZE  = 6;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    t_in_word   i_in;
    logic       o_done;
    t_out_word  o_out;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    int fail_count;
    int words_waiting;
    int stall_cycles;
    int gap_pct;

    int         tps_list [N_PHASES]  = '{1, 2, 255, 0, 3, 1, 4};
    int         tmo_list [N_PHASES]  = '{3, 6, 255, 0, 10, 0, 20};
    int         pct_list [N_PHASES]  = '{0, 86, 0, 13, 0, 86, 13};
    logic [6:0] call_pool [POOL_SIZE];

    call_number_history_display DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_in       (i_in),
        .o_done     (o_done),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    call_display_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_in            (i_in),
        .i_done          (o_done),
        .i_out           (o_out),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_words_waiting (words_waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // End the run if neither a command nor a display word moves for too long.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Hold the word until the block takes it, then return at the next falling edge.
    task automatic push_word(input logic [1:0] cmd, input logic [6:0] num);
        t_in_word w;
        w.command     = cmd;
        w.call_number = num;
        i_start <= 1'b1;
        i_in    <= w;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        if ($urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            i_in    <= t_in_word'($urandom);
            do @(negedge i_clk); while ($urandom_range(99) < gap_pct);
        end
    endtask

    task automatic send(input logic [1:0] cmd, input logic [6:0] num);
        push_word(cmd, num);
        idle_gap();
    endtask

    // Wait for every outstanding word, then let the block settle.
    task automatic drain();
        i_start <= 1'b0;
        do @(negedge i_clk); while (words_waiting != 0);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [7:0] tps, input logic [7:0] tmo);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TICKS_PER_SEC;
        i_cfg_data <= tps;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_TIMEOUT_SEC;
        i_cfg_data <= tmo;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_word();
        int         r;
        logic [6:0] num;
        r = $urandom_range(99);
        num = ($urandom_range(99) < 60) ? call_pool[$urandom_range(POOL_SIZE - 1)]
                                         : 7'($urandom_range(127));
        if (r < 55)
            send(CMD_TICK, 7'($urandom));
        else if (r < 85)
            send(CMD_CALL, num);
        else if (r < 95)
            send(CMD_REVIEW, 7'($urandom));
        else
            send(CMD_IDLE, 7'($urandom));
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_in         = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_TICKS_PER_SEC;
        i_cfg_data   = '0;
        stall_cycles = 0;
        gap_pct      = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty history in review mode, saturation, duplicates and wrap of the write slot.
        send(CMD_IDLE, 7'd0);
        send(CMD_TICK, 7'd127);
        send(CMD_REVIEW, 7'd0);
        send(CMD_CALL, 7'd0);
        send(CMD_CALL, 7'd127);
        send(CMD_CALL, 7'd99);
        send(CMD_CALL, 7'd100);
        send(CMD_CALL, 7'd45);
        send(CMD_CALL, 7'd12);
        send(CMD_CALL, 7'd78);
        send(CMD_CALL, 7'd33);
        send(CMD_REVIEW, 7'd0);
        send(CMD_IDLE, 7'd127);

        // One second per tick: count down to the timeout and clear.
        drain();
        set_regs(8'd1, 8'd2);
        send(CMD_CALL, 7'd64);
        repeat (4) send(CMD_TICK, 7'd0);
        send(CMD_CALL, 7'd7);
        send(CMD_REVIEW, 7'd0);
        send(CMD_TICK, 7'd0);

        // Zero ticks per second, then a rate below the pass count already reached.
        drain();
        set_regs(8'd0, 8'd255);
        send(CMD_TICK, 7'd0);
        send(CMD_CALL, 7'd50);
        drain();
        set_regs(8'd255, 8'd0);
        repeat (3) send(CMD_TICK, 7'd0);
        drain();
        set_regs(8'd2, 8'd0);
        send(CMD_TICK, 7'd0);

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            set_regs(8'(tps_list[p]), 8'(tmo_list[p]));
            gap_pct = pct_list[p];
            for (int i = 0; i < POOL_SIZE; i++)
                call_pool[i] = 7'($urandom_range(127));
            for (int n = 0; n < PHASE_LEN; n++) begin
                if ($urandom_range(99) < 2)
                    drain();
                random_word();
            end
        end

        drain();
        if (fail_count == 0 && words_waiting == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cnhd_pkg.sv
rtl/cnhd_cell.sv
rtl/call_number_history_display.sv
tb/sv/call_display_checker.sv
tb/sv/call_number_history_display_test.sv
